### rtl/core/aypf_pkg.sv
// Package: shared types, constants and the CORDIC arctangent table.
`timescale 1ns / 1ps
package aypf_pkg;

  localparam int ANG_GUARD = 24;
  localparam int ZW        = 36;
  localparam int TABLE_LEN = 28;
  localparam int GAIN_BITS = 31;

  localparam logic [GAIN_BITS-1:0] GAIN_Q30     = 31'd1768195363;
  localparam logic signed [ZW-1:0] DEG360_Q24   = 36'sd6039797760;
  localparam logic signed [ZW-1:0] DEG180_Q24   = 36'sd3019898880;
  localparam logic signed [ZW-1:0] DEG360_Q16   = 36'sd23592960;
  localparam logic signed [ZW-1:0] DEG90_Q16    = 36'sd5898240;
  localparam logic signed [ZW-1:0] ROUND_HALF   = 36'sd128;

  typedef struct packed {
    logic valid;
    logic yaw_zero;
    logic pitch_zero;
  } flags_t;

  function automatic logic signed [ZW-1:0] atan_q24(input int idx);
    logic signed [ZW-1:0] v;
    case (idx)
      0:  v = 36'sd754974720;
      1:  v = 36'sd445687602;
      2:  v = 36'sd235489088;
      3:  v = 36'sd119537938;
      4:  v = 36'sd60000934;
      5:  v = 36'sd30029717;
      6:  v = 36'sd15018523;
      7:  v = 36'sd7509720;
      8:  v = 36'sd3754917;
      9:  v = 36'sd1877466;
      10: v = 36'sd938734;
      11: v = 36'sd469367;
      12: v = 36'sd234684;
      13: v = 36'sd117342;
      14: v = 36'sd58671;
      15: v = 36'sd29335;
      16: v = 36'sd14668;
      17: v = 36'sd7334;
      18: v = 36'sd3667;
      19: v = 36'sd1833;
      20: v = 36'sd917;
      21: v = 36'sd458;
      22: v = 36'sd229;
      23: v = 36'sd115;
      24: v = 36'sd57;
      25: v = 36'sd29;
      26: v = 36'sd14;
      27: v = 36'sd7;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/aypf_front.sv
// Front end: coordinate deltas, quadrant pre-rotation and dz gain scaling.
`timescale 1ns / 1ps
module aypf_front #(
  parameter int CB = 24,
  parameter int W  = CB + 29
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start_i,
  input  logic signed [CB-1:0]         self_x,
  input  logic signed [CB-1:0]         self_y,
  input  logic signed [CB-1:0]         self_z,
  input  logic signed [CB-1:0]         target_x,
  input  logic signed [CB-1:0]         target_y,
  input  logic signed [CB-1:0]         target_z,
  output aypf_pkg::flags_t             flags_o,
  output logic signed [W-1:0]          x_o,
  output logic signed [W-1:0]          y_o,
  output logic signed [aypf_pkg::ZW-1:0] z_o,
  output logic signed [W-1:0]          yz_o
);
  localparam int DW = CB + 1;
  localparam int PW = DW + aypf_pkg::GAIN_BITS;
  localparam int SH = 30 - aypf_pkg::ANG_GUARD;

  aypf_pkg::flags_t fa_r, fa_nxt, fb_r;
  logic signed [DW-1:0] dx_r, dy_r, dz_r, dx_nxt, dy_nxt, dz_nxt;

  assign dx_nxt = DW'($signed(target_x)) - DW'($signed(self_x));
  assign dy_nxt = DW'($signed(target_y)) - DW'($signed(self_y));
  assign dz_nxt = DW'($signed(target_z)) - DW'($signed(self_z));

  always_comb begin
    fa_nxt.valid      = start_i;
    fa_nxt.yaw_zero   = (dx_nxt == '0) && (dy_nxt == '0);
    fa_nxt.pitch_zero = (dz_nxt == '0) && (dx_nxt == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fa_r <= '0;
    end else begin
      fa_r <= fa_nxt;
    end
    dx_r <= dx_nxt;
    dy_r <= dy_nxt;
    dz_r <= dz_nxt;
  end

  // stage B: scale by 2^24, fold left half-plane, gain on |dz|
  logic signed [W-1:0]  xs, ys, x_nxt, y_nxt, yz_nxt;
  logic signed [aypf_pkg::ZW-1:0] z_nxt;
  logic [DW-1:0] zmag;
  logic [PW-1:0] prod;
  logic signed [W-1:0] yzm;

  assign xs = W'(dx_r) <<< aypf_pkg::ANG_GUARD;
  assign ys = W'(dy_r) <<< aypf_pkg::ANG_GUARD;
  assign zmag = dz_r[DW-1] ? DW'(-dz_r) : DW'(dz_r);
  assign prod = PW'(zmag) * PW'(aypf_pkg::GAIN_Q30);
  assign yzm  = $signed(W'(prod >> SH));

  always_comb begin
    if (dx_r[DW-1]) begin
      x_nxt = -xs;
      y_nxt = -ys;
      z_nxt = aypf_pkg::DEG180_Q24;
    end else begin
      x_nxt = xs;
      y_nxt = ys;
      z_nxt = '0;
    end
    yz_nxt = dz_r[DW-1] ? -yzm : yzm;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb_r <= '0;
    end else begin
      fb_r <= fa_r;
    end
    x_o  <= x_nxt;
    y_o  <= y_nxt;
    z_o  <= z_nxt;
    yz_o <= yz_nxt;
  end

  assign flags_o = fb_r;
endmodule

### rtl/core/aypf_cordic_stage.sv
// One registered CORDIC vectoring iteration with a sideband word.
`timescale 1ns / 1ps
module aypf_cordic_stage #(
  parameter int W    = 53,
  parameter int STEP = 0,
  parameter int SBW  = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  aypf_pkg::flags_t               flags_i,
  input  logic signed [W-1:0]            x_i,
  input  logic signed [W-1:0]            y_i,
  input  logic signed [aypf_pkg::ZW-1:0] z_i,
  input  logic [SBW-1:0]                 sb_i,
  output aypf_pkg::flags_t               flags_o,
  output logic signed [W-1:0]            x_o,
  output logic signed [W-1:0]            y_o,
  output logic signed [aypf_pkg::ZW-1:0] z_o,
  output logic [SBW-1:0]                 sb_o
);
  localparam logic signed [aypf_pkg::ZW-1:0] ATAN = aypf_pkg::atan_q24(STEP);

  logic signed [W-1:0] xs, ys, x_nxt, y_nxt;
  logic signed [aypf_pkg::ZW-1:0] z_nxt;

  assign xs = x_i >>> STEP;
  assign ys = y_i >>> STEP;

  always_comb begin
    if (!y_i[W-1]) begin
      x_nxt = x_i + ys;
      y_nxt = y_i - xs;
      z_nxt = z_i + ATAN;
    end else begin
      x_nxt = x_i - ys;
      y_nxt = y_i + xs;
      z_nxt = z_i - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      flags_o <= '0;
    end else begin
      flags_o <= flags_i;
    end
    x_o  <= x_nxt;
    y_o  <= y_nxt;
    z_o  <= z_nxt;
    sb_o <= sb_i;
  end
endmodule

### rtl/core/aypf_back.sv
// Back end: yaw wrap, Q.24 to Q.16 rounding, pitch saturation and negation.
`timescale 1ns / 1ps
module aypf_back (
  input  logic                           clk,
  input  logic                           rst_n,
  input  aypf_pkg::flags_t               flags_i,
  input  logic signed [aypf_pkg::ZW-1:0] yaw_i,
  input  logic signed [aypf_pkg::ZW-1:0] pitch_i,
  output logic                           valid_o,
  output logic [24:0]                    yaw_o,
  output logic signed [23:0]             pitch_o
);
  localparam int ZW = aypf_pkg::ZW;

  logic signed [ZW-1:0] ya, yr, pm, pr, ps;
  logic [24:0]          yaw_nxt;
  logic signed [23:0]   pitch_nxt;

  always_comb begin
    ya = yaw_i[ZW-1] ? yaw_i + aypf_pkg::DEG360_Q24 : yaw_i;
    yr = (ya + aypf_pkg::ROUND_HALF) >>> 8;
    if (flags_i.yaw_zero || (yr >= aypf_pkg::DEG360_Q16)) begin
      yaw_nxt = '0;
    end else begin
      yaw_nxt = yr[24:0];
    end

    pm = pitch_i[ZW-1] ? -pitch_i : pitch_i;
    pr = (pm + aypf_pkg::ROUND_HALF) >>> 8;
    ps = (pr > aypf_pkg::DEG90_Q16) ? aypf_pkg::DEG90_Q16 : pr;
    if (flags_i.pitch_zero) begin
      pitch_nxt = '0;
    end else if (pitch_i[ZW-1]) begin
      pitch_nxt = ps[23:0];
    end else begin
      pitch_nxt = 24'(-ps);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= flags_i.valid;
    end
    yaw_o   <= yaw_nxt;
    pitch_o <= pitch_nxt;
  end
endmodule

### rtl/core/aim_yaw_pitch_from_positions_top.sv
// Top level: aim yaw / pitch from shooter and target positions, CORDIC pipeline.
//
//  channel | ports                                   | handshake
//  --------+-----------------------------------------+-------------------------------
//  input   | in_self_{x,y,z}, in_target_{x,y,z}      | word taken when start && !busy
//  result  | out_yaw_deg, out_pitch_deg              | out_valid strobe, one cycle
//
// A new word is taken every cycle; busy is held low.
// Pipeline: 2 front stages + 2*NS CORDIC stages + 1 output stage, where
// NS = min(CORDIC_STEPS, 28). The CORDIC stages form a chain of unrolled
// vectoring iterations.
// Synchronous active-low reset clears only the valid and zero-flag bits in flight.
// The receiver cannot stall: each result shows for exactly one cycle.
`timescale 1ns / 1ps
module aim_yaw_pitch_from_positions_top #(
  parameter int COORD_BITS   = 24,
  parameter int CORDIC_STEPS = 20
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_self_x,
  input  logic signed [COORD_BITS-1:0] in_self_y,
  input  logic signed [COORD_BITS-1:0] in_self_z,
  input  logic signed [COORD_BITS-1:0] in_target_x,
  input  logic signed [COORD_BITS-1:0] in_target_y,
  input  logic signed [COORD_BITS-1:0] in_target_z,
  output logic                         out_valid,
  output logic [24:0]                  out_yaw_deg,
  output logic signed [23:0]           out_pitch_deg
);
  localparam int NS = (CORDIC_STEPS < aypf_pkg::TABLE_LEN) ? CORDIC_STEPS
                                                           : aypf_pkg::TABLE_LEN;
  // delta + 2^24 scale + gain/sqrt2 headroom
  localparam int W  = COORD_BITS + 29;
  localparam int ZW = aypf_pkg::ZW;

  assign busy = 1'b0;

  aypf_pkg::flags_t      f1 [0:NS];
  logic signed [W-1:0]   x1 [0:NS];
  logic signed [W-1:0]   y1 [0:NS];
  logic signed [ZW-1:0]  z1 [0:NS];
  logic [W-1:0]          yz [0:NS];

  aypf_pkg::flags_t      f2 [0:NS];
  logic signed [W-1:0]   x2 [0:NS];
  logic signed [W-1:0]   y2 [0:NS];
  logic signed [ZW-1:0]  z2 [0:NS];
  logic [ZW-1:0]         ya [0:NS];

  logic signed [W-1:0]   yz0;

  aypf_front #(.CB(COORD_BITS), .W(W)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .start_i  (start),
    .self_x   (in_self_x),
    .self_y   (in_self_y),
    .self_z   (in_self_z),
    .target_x (in_target_x),
    .target_y (in_target_y),
    .target_z (in_target_z),
    .flags_o  (f1[0]),
    .x_o      (x1[0]),
    .y_o      (y1[0]),
    .z_o      (z1[0]),
    .yz_o     (yz0)
  );
  assign yz[0] = yz0;

  // first pass: (dx, dy) -> yaw, magnitude; scaled dz rides along
  for (genvar i = 0; i < NS; i++) begin : g_yaw
    aypf_cordic_stage #(.W(W), .STEP(i), .SBW(W)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .flags_i (f1[i]),
      .x_i     (x1[i]),
      .y_i     (y1[i]),
      .z_i     (z1[i]),
      .sb_i    (yz[i]),
      .flags_o (f1[i+1]),
      .x_o     (x1[i+1]),
      .y_o     (y1[i+1]),
      .z_o     (z1[i+1]),
      .sb_o    (yz[i+1])
    );
  end

  // second pass: (hypot*gain, dz*gain) -> elevation; yaw angle rides along
  assign f2[0] = f1[NS];
  assign x2[0] = x1[NS];
  assign y2[0] = $signed(yz[NS]);
  assign z2[0] = '0;
  assign ya[0] = z1[NS];

  for (genvar i = 0; i < NS; i++) begin : g_pitch
    aypf_cordic_stage #(.W(W), .STEP(i), .SBW(ZW)) u_stage (
      .clk     (clk),
      .rst_n   (rst_n),
      .flags_i (f2[i]),
      .x_i     (x2[i]),
      .y_i     (y2[i]),
      .z_i     (z2[i]),
      .sb_i    (ya[i]),
      .flags_o (f2[i+1]),
      .x_o     (x2[i+1]),
      .y_o     (y2[i+1]),
      .z_o     (z2[i+1]),
      .sb_o    (ya[i+1])
    );
  end

  aypf_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .flags_i (f2[NS]),
    .yaw_i   ($signed(ya[NS])),
    .pitch_i (z2[NS]),
    .valid_o (out_valid),
    .yaw_o   (out_yaw_deg),
    .pitch_o (out_pitch_deg)
  );
endmodule
